// ===== rtl/tbi_pkg.sv =====
// Package for the triangle barycentric interpolator.
// Holds the request and response beat types, widths and the tolerance reset value.
// No dependencies.
`default_nettype none
package tbi_pkg;

   // Field widths
   localparam int unsigned COORD_W = 32;
   localparam int unsigned TOL_W   = 21;

   // Quotient bits produced by the pipelined divider, one per stage
   localparam int unsigned DIV_STEPS = 32;

   // Tolerance after reset, about 1e-6 in Q2.30
   localparam logic [TOL_W-1:0] TOL_RESET = 21'd1074;

   // One query: triangle corners, query point and corner values (Q16.16)
   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] value_a;
      logic signed [COORD_W-1:0] value_b;
      logic signed [COORD_W-1:0] value_c;
   } req_type;

   // One result: interpolated value and inside flag
   typedef struct packed {
      logic signed [COORD_W-1:0] interp_value;
      logic                      inside_res;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/triangle_barycentric_interpolator.sv =====
// Triangle barycentric interpolator: weights, border test and weighted value.
// Depends on tbi_pkg for the beat types, widths and the tolerance reset value.
// Each request beat passes through the whole pipeline, including the 32-stage divider, to the response beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output is stalled.
// Reset (synchronous, active high) clears all valid bits and loads the default tolerance.
`default_nettype none
module triangle_barycentric_interpolator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire tbi_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output tbi_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [tbi_pkg::TOL_W-1:0]   csr_data
);

   localparam int unsigned NDIV = tbi_pkg::DIV_STEPS;
   // 6 front stages, NDIV divider stages, 4 back stages
   localparam int unsigned NSTG = 6 + NDIV + 4;

   // One divider lane: partial remainder, remaining dividend bits, quotient
   typedef struct packed {
      logic [65:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic        ovf;
      logic        neg;
   } lane_type;

   // Data that rides alongside the divider
   typedef struct packed {
      logic [65:0]        md;
      logic               degen;
      logic signed [31:0] va;
      logic signed [31:0] vb;
      logic signed [31:0] vc;
   } side_type;

   logic [NSTG-1:0] vld_ff;
   logic            en;
   logic [tbi_pkg::TOL_W-1:0] tol_ff;

   // Global advance: hold everything while the output beat is stalled
   assign en        = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[NSTG-1];

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tbi_pkg::TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // Stage 1: edge vectors relative to corner A
   logic signed [32:0] ux_ff, uy_ff, vx_ff, vy_ff, px_ff, py_ff;
   logic signed [31:0] s1_va_ff, s1_vb_ff, s1_vc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= 33'(req_data.c_x) - 33'(req_data.a_x);
         uy_ff <= 33'(req_data.c_y) - 33'(req_data.a_y);
         vx_ff <= 33'(req_data.b_x) - 33'(req_data.a_x);
         vy_ff <= 33'(req_data.b_y) - 33'(req_data.a_y);
         px_ff <= 33'(req_data.query_x) - 33'(req_data.a_x);
         py_ff <= 33'(req_data.query_y) - 33'(req_data.a_y);
         s1_va_ff <= req_data.value_a;
         s1_vb_ff <= req_data.value_b;
         s1_vc_ff <= req_data.value_c;
      end
   end

   // Stage 2: the six products of the three cross products
   logic signed [65:0] d0_ff, d1_ff, c0_ff, c1_ff, b0_ff, b1_ff;
   logic signed [31:0] s2_va_ff, s2_vb_ff, s2_vc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= ux_ff * vy_ff;
         d1_ff <= uy_ff * vx_ff;
         c0_ff <= px_ff * vy_ff;
         c1_ff <= py_ff * vx_ff;
         b0_ff <= ux_ff * py_ff;
         b1_ff <= uy_ff * px_ff;
         s2_va_ff <= s1_va_ff;
         s2_vb_ff <= s1_vb_ff;
         s2_vc_ff <= s1_vc_ff;
      end
   end

   // Stage 3: determinant and the two weight numerators
   logic signed [66:0] det_ff, nc_ff, nb_ff;
   logic signed [31:0] s3_va_ff, s3_vb_ff, s3_vc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= 67'(d0_ff) - 67'(d1_ff);
         nc_ff  <= 67'(c0_ff) - 67'(c1_ff);
         nb_ff  <= 67'(b0_ff) - 67'(b1_ff);
         s3_va_ff <= s2_va_ff;
         s3_vb_ff <= s2_vb_ff;
         s3_vc_ff <= s2_vc_ff;
      end
   end

   // Stage 4: magnitudes and quotient signs
   logic [65:0] md_ff, mc_ff, mb_ff;
   logic        s4_negc_ff, s4_negb_ff, s4_degen_ff;
   logic signed [31:0] s4_va_ff, s4_vb_ff, s4_vc_ff;
   logic [66:0] abs_d, abs_c, abs_b;
   always_comb begin
      abs_d = det_ff[66] ? 67'(-det_ff) : 67'(det_ff);
      abs_c = nc_ff[66]  ? 67'(-nc_ff)  : 67'(nc_ff);
      abs_b = nb_ff[66]  ? 67'(-nb_ff)  : 67'(nb_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         md_ff <= abs_d[65:0];
         mc_ff <= abs_c[65:0];
         mb_ff <= abs_b[65:0];
         s4_negc_ff  <= nc_ff[66] ^ det_ff[66];
         s4_negb_ff  <= nb_ff[66] ^ det_ff[66];
         s4_degen_ff <= (det_ff == '0);
         s4_va_ff <= s3_va_ff;
         s4_vb_ff <= s3_vb_ff;
         s4_vc_ff <= s3_vc_ff;
      end
   end

   // Stage 5: rounded dividends, numerator * 2^30 plus half the divisor
   logic [97:0] nmc_ff, nmb_ff;
   side_type    s5_side_ff;
   logic        s5_negc_ff, s5_negb_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         nmc_ff <= {2'b00, mc_ff, 30'd0} + 98'(md_ff[65:1]);
         nmb_ff <= {2'b00, mb_ff, 30'd0} + 98'(md_ff[65:1]);
         s5_negc_ff <= s4_negc_ff;
         s5_negb_ff <= s4_negb_ff;
         s5_side_ff.md    <= md_ff;
         s5_side_ff.degen <= s4_degen_ff;
         s5_side_ff.va    <= s4_va_ff;
         s5_side_ff.vb    <= s4_vb_ff;
         s5_side_ff.vc    <= s4_vc_ff;
      end
   end

   // Stage 6: quotient overflow check (quotient of 2^32 or more) and divider load
   lane_type lc_ff [0:NDIV];
   lane_type lb_ff [0:NDIV];
   side_type sd_ff [0:NDIV];
   always_ff @(posedge clock) begin
      if (en) begin
         lc_ff[0].ovf <= (nmc_ff[97:32] >= s5_side_ff.md);
         lc_ff[0].rem <= nmc_ff[97:32];
         lc_ff[0].low <= nmc_ff[31:0];
         lc_ff[0].quo <= '0;
         lc_ff[0].neg <= s5_negc_ff;
         lb_ff[0].ovf <= (nmb_ff[97:32] >= s5_side_ff.md);
         lb_ff[0].rem <= nmb_ff[97:32];
         lb_ff[0].low <= nmb_ff[31:0];
         lb_ff[0].quo <= '0;
         lb_ff[0].neg <= s5_negb_ff;
         sd_ff[0]     <= s5_side_ff;
      end
   end

   // Restoring divider: one quotient bit per stage for each weight
   function automatic lane_type div_step(input lane_type l, input logic [65:0] md);
      logic [66:0] trial;
      lane_type    r;
      trial = {l.rem, l.low[31]};
      r     = l;
      r.low = {l.low[30:0], 1'b0};
      if (trial >= {1'b0, md}) begin
         r.rem = 66'(trial - {1'b0, md});
         r.quo = {l.quo[30:0], 1'b1};
      end else begin
         r.rem = trial[65:0];
         r.quo = {l.quo[30:0], 1'b0};
      end
      return r;
   endfunction

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            lc_ff[k+1] <= div_step(lc_ff[k], sd_ff[k].md);
            lb_ff[k+1] <= div_step(lb_ff[k], sd_ff[k].md);
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   // Saturate a quotient into the signed Q2.30 range
   function automatic logic signed [31:0] sat_weight(input lane_type l);
      logic big;
      big = l.ovf || (l.quo[31] && (l.quo[30:0] != '0));
      if (l.neg) begin
         return big ? 32'sh8000_0000 : 32'(-$signed({1'b0, l.quo}));
      end
      return (big || l.quo[31]) ? 32'sh7FFF_FFFF : $signed(l.quo);
   endfunction

   // Stage F1: saturated weights and the third weight
   logic signed [31:0] wc_ff, wb_ff;
   logic signed [33:0] wa_ff;
   side_type           f1_side_ff;
   logic signed [31:0] wc_in, wb_in;
   always_comb begin
      wc_in = sat_weight(lc_ff[NDIV]);
      wb_in = sat_weight(lb_ff[NDIV]);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         wc_ff <= wc_in;
         wb_ff <= wb_in;
         wa_ff <= 34'sd1073741824 - 34'(wc_in) - 34'(wb_in);
         f1_side_ff <= sd_ff[NDIV];
      end
   end

   // A slightly negative weight is snapped to zero; result is negative if still below
   function automatic logic snap_neg(input logic signed [33:0] w,
                                     input logic [tbi_pkg::TOL_W-1:0] tol);
      logic signed [34:0] t;
      t = 35'(w) + $signed({14'd0, tol});
      return w[33] && (t <= 0);
   endfunction

   function automatic logic [31:0] snap_val(input logic signed [33:0] w,
                                            input logic [tbi_pkg::TOL_W-1:0] tol);
      logic signed [34:0] t;
      t = 35'(w) + $signed({14'd0, tol});
      return (w[33] && (t > 0)) ? 32'd0 : w[31:0];
   endfunction

   // Stage F2: snapping and the inside test
   logic [31:0]        ua_ff, ub_ff, uc_ff;
   logic               f2_inside_ff;
   logic signed [31:0] f2_va_ff, f2_vb_ff, f2_vc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff <= snap_val(wa_ff, tol_ff);
         ub_ff <= snap_val(34'(wb_ff), tol_ff);
         uc_ff <= snap_val(34'(wc_ff), tol_ff);
         f2_inside_ff <= !f1_side_ff.degen && !snap_neg(wa_ff, tol_ff)
                         && !snap_neg(34'(wb_ff), tol_ff) && !snap_neg(34'(wc_ff), tol_ff);
         f2_va_ff <= f1_side_ff.va;
         f2_vb_ff <= f1_side_ff.vb;
         f2_vc_ff <= f1_side_ff.vc;
      end
   end

   // Stage F3: weight times corner value
   logic signed [64:0] pa_ff, pb_ff, pc_ff;
   logic               f3_inside_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= $signed({1'b0, ua_ff}) * 65'(f2_va_ff);
         pb_ff <= $signed({1'b0, ub_ff}) * 65'(f2_vb_ff);
         pc_ff <= $signed({1'b0, uc_ff}) * 65'(f2_vc_ff);
         f3_inside_ff <= f2_inside_ff;
      end
   end

   // Stage F4: sum, round to Q16.16, saturate, zero when outside; this is the output register
   logic signed [66:0] acc;
   logic signed [36:0] res;
   logic signed [31:0] val_in;
   always_comb begin
      acc = 67'(pa_ff) + 67'(pb_ff) + 67'(pc_ff) + 67'sd536870912;
      res = 37'(acc >>> 30);
      if (res > 37'sd2147483647) begin
         val_in = 32'sh7FFF_FFFF;
      end else if (res < -37'sd2147483648) begin
         val_in = 32'sh8000_0000;
      end else begin
         val_in = res[31:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data.interp_value <= f3_inside_ff ? val_in : 32'sd0;
         rsp_data.inside_res   <= f3_inside_ff;
      end
   end

   // Checks on the internal pipeline
   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.inside_res |-> rsp_data.interp_value == 32'sd0)
      else $error("outside result carries a nonzero value");

   a_degen_outside : assert property (@(posedge clock) disable iff (reset)
      en && f1_side_ff.degen |=> !f2_inside_ff)
      else $error("degenerate triangle reported inside");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while the output beat was stalled");

   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> tol_ff == $past(csr_data))
      else $error("tolerance write was lost");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the triangle barycentric interpolator.
// Drives random and directed queries, predicts results in exact integer math.
// Depends on tbi_pkg and triangle_barycentric_interpolator.
`default_nettype none
module tb;

   localparam int LATENCY   = 42;
   localparam longint LIMIT = 2000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   tbi_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   tbi_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [tbi_pkg::TOL_W-1:0] csr_data;

   logic [tbi_pkg::TOL_W-1:0] tolerance;
   tbi_pkg::rsp_type expected_q[$];
   int mismatches;
   longint cycles;
   int hold_cycles;
   int stall_run;
   bit random_stall_on;

   triangle_barycentric_interpolator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Rounded quotient n*2^30/d in Q2.30, saturated.
   function automatic longint calc_weight(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] mn, md, q;
      bit neg;
      longint mag;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = ((mn << 30) + (md >> 1)) / md;
      mag = (q > (128'd1 << 31)) ? (longint'(1) << 31) : longint'(q);
      if (neg) return -mag;
      return (mag > 64'h7FFFFFFF) ? 64'h7FFFFFFF : mag;
   endfunction

   function automatic longint snap_weight(longint w);
      if (w < 0 && w > -longint'(tolerance)) return 0;
      return w;
   endfunction

   // Expected response for one query.
   function automatic tbi_pkg::rsp_type interpolate(tbi_pkg::req_type r);
      logic signed [127:0] ux, uy, vx, vy, px, py, d, nc, nb, acc;
      longint wa, wb, wc, res;
      tbi_pkg::rsp_type o;
      o = '0;
      ux = r.c_x - r.a_x; uy = r.c_y - r.a_y;
      vx = r.b_x - r.a_x; vy = r.b_y - r.a_y;
      px = r.query_x - r.a_x; py = r.query_y - r.a_y;
      ux = 128'(signed'(r.c_x)) - r.a_x; uy = 128'(signed'(r.c_y)) - r.a_y;
      vx = 128'(signed'(r.b_x)) - r.a_x; vy = 128'(signed'(r.b_y)) - r.a_y;
      px = 128'(signed'(r.query_x)) - r.a_x; py = 128'(signed'(r.query_y)) - r.a_y;
      d = ux * vy - uy * vx;
      if (d == 0) return o;
      nc = px * vy - py * vx;
      nb = ux * py - uy * px;
      wc = calc_weight(nc, d);
      wb = calc_weight(nb, d);
      wa = (longint'(1) << 30) - wc - wb;
      wc = snap_weight(wc);
      wb = snap_weight(wb);
      wa = snap_weight(wa);
      if (wa < 0 || wb < 0 || wc < 0) return o;
      acc = 128'(wa) * r.value_a + 128'(wb) * r.value_b + 128'(wc) * r.value_c;
      acc = acc + (128'sd1 <<< 29);
      acc = acc >>> 30;
      if (acc > 128'sh7FFFFFFF) res = 64'h7FFFFFFF;
      else if (acc < -(128'sd1 <<< 31)) res = -(longint'(1) << 31);
      else res = longint'(acc);
      o.interp_value = res[31:0];
      o.inside_res = 1'b1;
      return o;
   endfunction

   // Response stall: random gaps, a few long ones, or a long hold-off when requested.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (random_stall_on) begin
         if (r == 99) begin
            stall_run <= $urandom_range(5, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (r < 20);
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response check against the oldest expectation.
   always @(posedge clock) begin
      tbi_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_data);
         end else begin
            e = expected_q.pop_front();
            if (e.interp_value !== rsp_data.interp_value
                  || e.inside_res !== rsp_data.inside_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %h inside %b, got value %h inside %b",
                           e.interp_value, e.inside_res,
                           rsp_data.interp_value, rsp_data.inside_res);
            end
         end
      end
   end

   // Send one query beat, with a random gap ahead of it when gaps is set. Valid stays high after the
   // beat is taken so that the next beat can follow back to back.
   task automatic send_query(tbi_pkg::req_type r, bit gaps = 1);
      int g;
      if (gaps) begin
         g = $urandom_range(0, 99);
         g = (g < 70) ? 0 : (g < 95) ? $urandom_range(1, 3) : $urandom_range(5, 40);
         if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(interpolate(r));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [tbi_pkg::TOL_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tolerance = v;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'(signed'($urandom_range(0, 65535)) - 32768) <<< 8;
      endcase
   endfunction

   // Random triangle and a point; mostly inside via a convex combination.
   function automatic tbi_pkg::req_type rand_query();
      tbi_pkg::req_type r;
      longint ka, kb, kc, s;
      r.a_x = rand_coord(); r.a_y = rand_coord();
      r.b_x = rand_coord(); r.b_y = rand_coord();
      r.c_x = rand_coord(); r.c_y = rand_coord();
      r.value_a = $urandom(); r.value_b = $urandom(); r.value_c = $urandom();
      case ($urandom_range(0, 9))
         0, 1: begin
            r.query_x = rand_coord();
            r.query_y = rand_coord();
         end
         2: begin
            // Point on an edge, or on a corner.
            r.query_x = 32'((longint'(r.a_x) + r.b_x) >>> 1);
            r.query_y = 32'((longint'(r.a_y) + r.b_y) >>> 1);
            if ($urandom_range(0, 1)) begin
               r.query_x = r.c_x; r.query_y = r.c_y;
            end
         end
         3: begin
            // Degenerate: collinear corners.
            r.c_x = r.b_x; r.c_y = r.b_y;
            r.query_x = r.a_x; r.query_y = r.a_y;
         end
         default: begin
            ka = $urandom_range(0, 1000); kb = $urandom_range(0, 1000);
            kc = $urandom_range(0, 1000); s = ka + kb + kc + 1;
            r.query_x = 32'((ka * r.a_x + kb * r.b_x + kc * r.c_x) / s);
            r.query_y = 32'((ka * r.a_y + kb * r.b_y + kc * r.c_y) / s);
         end
      endcase
      return r;
   endfunction

   function automatic tbi_pkg::req_type tri_query(int qx, int qy, int va, int vb, int vc);
      tbi_pkg::req_type r;
      r.a_x = 0; r.a_y = 0;
      r.b_x = 32'h00100000; r.b_y = 0;
      r.c_x = 0; r.c_y = 32'h00100000;
      r.query_x = qx; r.query_y = qy;
      r.value_a = va; r.value_b = vb; r.value_c = vc;
      return r;
   endfunction

   // Directed corners, borders, near-border points, degenerate and saturation cases.
   task automatic test_directed();
      tbi_pkg::req_type r;
      send_query(tri_query(0, 0, 32'h00010000, 2, 3));
      send_query(tri_query(32'h00100000, 0, 1, 32'h7FFFFFFF, 3));
      send_query(tri_query(0, 32'h00100000, 1, 2, 32'h80000000));
      send_query(tri_query(32'h00080000, 32'h00080000, 5, 6, 7));
      send_query(tri_query(32'h00040000, 32'h00040000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h7FFFFFFF));
      send_query(tri_query(32'h00040000, 32'h00040000, 32'h80000000, 32'h80000000,
                           32'h80000000));
      send_query(tri_query(-1, 32'h00040000, 1, 2, 3));
      send_query(tri_query(-32, 32'h00040000, 1, 2, 3));
      send_query(tri_query(32'h00080000, 32'h00080001, 1, 2, 3));
      send_query(tri_query(32'h00200000, 32'h00200000, 1, 2, 3));
      send_query(tri_query(32'h80000000, 32'h7FFFFFFF, 1, 2, 3));
      r = tri_query(0, 0, 1, 2, 3);
      r.b_x = 32'h7FFFFFFF; r.b_y = 32'h80000000;
      r.c_x = 32'h80000000; r.c_y = 32'h7FFFFFFF;
      r.a_x = 32'h80000000; r.a_y = 32'h80000000;
      send_query(r);
      r.c_x = r.b_x; r.c_y = r.b_y;
      send_query(r);
      r = tri_query(32'h00010000, 0, 9, 8, 7);
      r.b_x = 32'h00020000; r.c_x = 32'h00030000; r.c_y = 0;
      send_query(r);
      r = tri_query(32'h00000001, 32'h00000001, 1, 1, 1);
      r.b_x = 1; r.c_y = 1;
      send_query(r);
      drain();
   endtask

   // Random queries under a given tolerance.
   task automatic test_random(int count, logic [tbi_pkg::TOL_W-1:0] tol);
      write_tolerance(tol);
      repeat (count) send_query(rand_query());
   endtask

   // Long output hold-off while queries keep coming, so the input stalls.
   task automatic test_backpressure();
      drain();
      hold_cycles = 300;
      repeat (120) send_query(rand_query(), 0);
      drain();
   endtask

   initial begin
      cycles = 0;
      mismatches = 0;
      hold_cycles = 0;
      random_stall_on = 1'b0;
      tolerance = tbi_pkg::TOL_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_tolerance(21'h1FFFFF);
      test_directed();
      write_tolerance(0);
      test_directed();
      random_stall_on = 1'b1;
      test_random(400, tbi_pkg::TOL_RESET);
      test_random(300, 0);
      test_random(300, 21'd1048576);
      test_random(300, 21'h1FFFFF);
      test_random(300, $urandom_range(0, 21'h1FFFFF));
      test_backpressure();
      drain();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
